@@ rtl/core/sbcl_pkg.sv @@
// shared types and constants for the segment box chord length block
package sbcl_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned LenBits   = 25;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] box_low_x;
    logic signed [CoordBits-1:0] box_low_y;
    logic signed [CoordBits-1:0] box_high_x;
    logic signed [CoordBits-1:0] box_high_y;
  } sbcl_in_t;

  typedef struct packed {
    logic               crosses;
    logic [LenBits-1:0] chord_length;
    logic               bad_box;
  } sbcl_out_t;

endpackage

@@ rtl/core/segment_box_chord_length.sv @@
// segment box chord length top level
// Usage: one transaction on in carries a segment and a box; one transaction
// on out carries crosses, chord_length and bad_box for it, in order.
// Channels use valid and stall; an item is taken when valid is high and stall
// is low. One item is accepted every cycle while out is not stalled.
// Pipeline: edge test with one-bit-per-stage divider, then three distance
// stages and a one-bit-per-stage square root.
// The whole pipeline advances as one: a stall on out with a valid result at
// the tail freezes every stage, and in_stall_o follows it, so nothing is lost
// or repeated. Reset clears all valid bits; no result is shown after reset
// until an item has gone through.
module segment_box_chord_length
  import sbcl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sbcl_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sbcl_out_t out_data_o
);
  localparam int unsigned W    = CoordBits + 1;
  localparam int unsigned ELat = 2 + 2 * W + 1;
  localparam int unsigned SqW  = 2 * LenBits;
  localparam int unsigned SqSt = LenBits + 1;
  localparam int unsigned Lat  = ELat + 3 + SqSt;

  logic en;
  logic vld_q [Lat+1];
  assign en = !(vld_q[Lat] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_q[0] = in_valid_i;

  for (genvar s = 0; s < Lat; s++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  sbcl_in_t d;
  assign d = in_data_i;

  // four edges: bottom, right, top, left
  logic hit [4];
  logic signed [CoordBits+1:0] t [4];
  sbcl_edge u_bot (.clk_i, .en_i(en), .au_i(d.start_y), .av_i(d.start_x),
    .bu_i(d.end_y), .bv_i(d.end_x), .uk_i(d.box_low_y), .v0_i(d.box_low_x),
    .v1_i(d.box_high_x), .hit_o(hit[0]), .v_o(t[0]));
  sbcl_edge u_rgt (.clk_i, .en_i(en), .au_i(d.start_x), .av_i(d.start_y),
    .bu_i(d.end_x), .bv_i(d.end_y), .uk_i(d.box_high_x), .v0_i(d.box_low_y),
    .v1_i(d.box_high_y), .hit_o(hit[1]), .v_o(t[1]));
  sbcl_edge u_top (.clk_i, .en_i(en), .au_i(d.start_y), .av_i(d.start_x),
    .bu_i(d.end_y), .bv_i(d.end_x), .uk_i(d.box_high_y), .v0_i(d.box_low_x),
    .v1_i(d.box_high_x), .hit_o(hit[2]), .v_o(t[2]));
  sbcl_edge u_lft (.clk_i, .en_i(en), .au_i(d.start_x), .av_i(d.start_y),
    .bu_i(d.end_x), .bv_i(d.end_y), .uk_i(d.box_low_x), .v0_i(d.box_low_y),
    .v1_i(d.box_high_y), .hit_o(hit[3]), .v_o(t[3]));

  // input fields delayed to match the edge units
  sbcl_in_t in_dl [ELat+1];
  logic     bad_dl [ELat+1];
  assign in_dl[0]  = d;
  assign bad_dl[0] = (d.box_low_x > d.box_high_x) || (d.box_low_y > d.box_high_y);
  for (genvar s = 0; s < ELat; s++) begin : g_idl
    always_ff @(posedge clk_i) begin
      if (en) begin
        in_dl[s+1]  <= in_dl[s];
        bad_dl[s+1] <= bad_dl[s];
      end
    end
  end

  // select endpoints of the chord
  sbcl_in_t g;
  logic signed [W:0] p0x, p0y, p1x, p1y, px [4], py [4];
  logic [2:0] n;
  logic b_in, a_in, use_len, any;
  always_comb begin
    g = in_dl[ELat];
    px[0] = (W+1)'(t[0]);           py[0] = (W+1)'(g.box_low_y);
    px[1] = (W+1)'(g.box_high_x);   py[1] = (W+1)'(t[1]);
    px[2] = (W+1)'(t[2]);           py[2] = (W+1)'(g.box_high_y);
    px[3] = (W+1)'(g.box_low_x);    py[3] = (W+1)'(t[3]);
    n = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
    p0x = '0; p0y = '0; p1x = '0; p1y = '0;
    for (int k = 3; k >= 0; k--) begin
      if (hit[k]) begin
        p1x = p0x; p1y = p0y; p0x = px[k]; p0y = py[k];
      end
    end
    b_in = g.end_x > g.box_low_x && g.end_y > g.box_low_y
        && g.end_x < g.box_high_x && g.end_y < g.box_high_y;
    a_in = g.start_x > g.box_low_x && g.start_y > g.box_low_y
        && g.start_x < g.box_high_x && g.start_y < g.box_high_y;
    use_len = 1'b0;
    if (n == 3'd2) begin
      use_len = 1'b1;
    end else if (n == 3'd1) begin
      if (b_in) begin
        use_len = 1'b1; p1x = (W+1)'(g.end_x); p1y = (W+1)'(g.end_y);
      end else if (a_in) begin
        use_len = 1'b1; p1x = (W+1)'(g.start_x); p1y = (W+1)'(g.start_y);
      end
    end
    any = (n != 3'd0) && !bad_dl[ELat];
    use_len = use_len && !bad_dl[ELat];
  end

  // stage a: differences
  logic signed [W+1:0] ddx_q, ddy_q;
  logic c1_q, b1_q, u1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ddx_q <= (W+2)'(p0x) - (W+2)'(p1x);
      ddy_q <= (W+2)'(p0y) - (W+2)'(p1y);
      c1_q  <= any; b1_q <= bad_dl[ELat]; u1_q <= use_len;
    end
  end

  // stage b: magnitudes and saturation check
  logic [W+1:0] mx, my;
  assign mx = ddx_q[W+1] ? (W+2)'(-ddx_q) : (W+2)'(ddx_q);
  assign my = ddy_q[W+1] ? (W+2)'(-ddy_q) : (W+2)'(ddy_q);
  logic [LenBits-1:0] mx_q, my_q;
  logic sat_q, c2_q, b2_q, u2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= (mx > (W+2)'(LenMax)) || (my > (W+2)'(LenMax));
      mx_q  <= LenBits'(mx); my_q <= LenBits'(my);
      c2_q  <= c1_q; b2_q <= b1_q; u2_q <= u1_q;
    end
  end

  // stage c: sum of squares
  logic [SqW:0] ss_q;
  logic sat3_q, c3_q, b3_q, u3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_q   <= (SqW+1)'(mx_q) * (SqW+1)'(mx_q) + (SqW+1)'(my_q) * (SqW+1)'(my_q);
      sat3_q <= sat_q; c3_q <= c2_q; b3_q <= b2_q; u3_q <= u2_q;
    end
  end

  // square root, two radicand bits per stage
  logic [SqW+1:0]   rad_q [SqSt+1];
  logic [LenBits:0] root_q [SqSt+1];
  logic [LenBits+2:0] rm_q [SqSt+1];
  logic sat_s [SqSt+1], c_s [SqSt+1], b_s [SqSt+1], u_s [SqSt+1];
  always_comb begin
    rad_q[0] = (SqW+2)'(ss_q); root_q[0] = '0; rm_q[0] = '0;
    sat_s[0] = sat3_q; c_s[0] = c3_q; b_s[0] = b3_q; u_s[0] = u3_q;
  end
  for (genvar s = 0; s < SqSt; s++) begin : g_sq
    logic [LenBits+2:0] tr, trial;
    always_comb begin
      tr    = {rm_q[s][LenBits:0], rad_q[s][SqW+1:SqW]};
      trial = {root_q[s], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[s+1] <= {rad_q[s][SqW-1:0], 2'b00};
        if (tr >= trial) begin
          rm_q[s+1]   <= tr - trial;
          root_q[s+1] <= {root_q[s][LenBits-1:0], 1'b1};
        end else begin
          rm_q[s+1]   <= tr;
          root_q[s+1] <= {root_q[s][LenBits-1:0], 1'b0};
        end
        sat_s[s+1] <= sat_s[s]; c_s[s+1] <= c_s[s];
        b_s[s+1] <= b_s[s]; u_s[s+1] <= u_s[s];
      end
    end
  end

  // result assembly
  logic [LenBits:0] root;
  assign root = root_q[SqSt];
  always_comb begin
    out_valid_o = vld_q[Lat];
    out_data_o.crosses = c_s[SqSt];
    out_data_o.bad_box = b_s[SqSt];
    if (!u_s[SqSt]) out_data_o.chord_length = '0;
    else if (sat_s[SqSt] || root[LenBits]) out_data_o.chord_length = LenMax;
    else out_data_o.chord_length = root[LenBits-1:0];
  end
endmodule

@@ rtl/core/sbcl_div.sv @@
// pipelined restoring divider, one quotient bit per stage, stall aware
module sbcl_div
  import sbcl_pkg::*;
#(
  parameter int unsigned NumBits = 50,
  parameter int unsigned DenBits = 26
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic [NumBits-1:0] quo_o,
  output logic               rem_nz_o
);
  logic [NumBits-1:0] num_q [NumBits+1];
  logic [DenBits-1:0] den_q [NumBits+1];
  logic [DenBits:0]   rem_q [NumBits+1];

  always_comb begin
    num_q[0] = num_i;
    den_q[0] = den_i;
    rem_q[0] = '0;
  end

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [DenBits+1:0] trial;
    logic [DenBits:0]   rem_d;
    logic [NumBits-1:0] num_d;
    always_comb begin
      trial = {rem_q[s], num_q[s][NumBits-1]};
      num_d = {num_q[s][NumBits-2:0], 1'b0};
      if (trial >= {2'b00, den_q[s]}) begin
        rem_d    = (DenBits+1)'(trial - {2'b00, den_q[s]});
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[DenBits:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_d;
        den_q[s+1] <= den_q[s];
        rem_q[s+1] <= rem_d;
      end
    end
  end

  assign quo_o    = num_q[NumBits];
  assign rem_nz_o = |rem_q[NumBits];
endmodule

@@ rtl/core/sbcl_edge.sv @@
// one box edge test: strict crossing check and truncated crossing coordinate
module sbcl_edge
  import sbcl_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [CoordBits-1:0] au_i,
  input  logic signed [CoordBits-1:0] av_i,
  input  logic signed [CoordBits-1:0] bu_i,
  input  logic signed [CoordBits-1:0] bv_i,
  input  logic signed [CoordBits-1:0] uk_i,
  input  logic signed [CoordBits-1:0] v0_i,
  input  logic signed [CoordBits-1:0] v1_i,
  output logic                        hit_o,
  output logic signed [CoordBits+1:0] v_o
);
  localparam int unsigned W  = CoordBits + 1;
  localparam int unsigned PW = 2 * W;

  // stage 1: differences, sign normalization, span checks
  logic signed [W-1:0] eu, ev, ds, e0, d0, d1;
  logic                ok1;
  always_comb begin
    eu = W'(bu_i) - W'(au_i);
    ev = W'(bv_i) - W'(av_i);
    ds = W'(uk_i) - W'(au_i);
    d0 = W'(v0_i) - W'(av_i);
    d1 = W'(v1_i) - W'(av_i);
    e0 = eu;
    if (eu < 0) begin
      e0 = -eu;
      ds = W'(au_i) - W'(uk_i);
    end
    ok1 = (eu != 0) && (v0_i < v1_i)
       && !((uk_i < au_i && uk_i < bu_i) || (uk_i > au_i && uk_i > bu_i));
  end

  logic signed [W-1:0] ds_q, ev_q, e_q, d0_q, d1_q;
  logic signed [CoordBits-1:0] av_q, bv_q;
  logic ok_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q <= ds; ev_q <= ev; e_q <= e0; d0_q <= d0; d1_q <= d1;
      av_q <= av_i; bv_q <= bv_i; ok_q <= ok1;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_q, l0_q, l1_q;
  logic signed [CoordBits-1:0] av2_q, bv2_q;
  logic [W-1:0] e2_q;
  logic ok2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= PW'(ds_q) * PW'(ev_q);
      l0_q  <= PW'(d0_q) * PW'(e_q);
      l1_q  <= PW'(d1_q) * PW'(e_q);
      av2_q <= av_q; bv2_q <= bv_q; e2_q <= e_q; ok2_q <= ok_q;
    end
  end

  // stage 3: strict compare, magnitude into divider
  logic [PW-1:0] mag;
  assign mag = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);

  logic [PW-1:0] quo;
  logic          rnz;
  sbcl_div #(.NumBits(PW), .DenBits(W)) u_div (
    .clk_i, .en_i, .num_i(mag), .den_i(e2_q), .quo_o(quo), .rem_nz_o(rnz)
  );

  // side info delayed alongside the divider
  logic ok_dl [PW+1];
  logic neg_dl [PW+1];
  logic signed [CoordBits-1:0] av_dl [PW+1];
  logic signed [CoordBits-1:0] bv_dl [PW+1];
  always_comb begin
    ok_dl[0]  = ok2_q && (p_q > l0_q) && (p_q < l1_q);
    neg_dl[0] = p_q[PW-1];
    av_dl[0]  = av2_q;
    bv_dl[0]  = bv2_q;
  end
  for (genvar s = 0; s < PW; s++) begin : g_dl
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ok_dl[s+1] <= ok_dl[s]; neg_dl[s+1] <= neg_dl[s];
        av_dl[s+1] <= av_dl[s]; bv_dl[s+1] <= bv_dl[s];
      end
    end
  end

  // final stage: truncate toward zero and bounding box check
  logic signed [PW:0] v;
  logic               ok_f;
  logic signed [PW:0] avx, bvx;
  always_comb begin
    avx = (PW+1)'(av_dl[PW]);
    bvx = (PW+1)'(bv_dl[PW]);
    v = neg_dl[PW] ? avx - (PW+1)'(quo) : avx + (PW+1)'(quo);
    if (rnz) begin
      if (!neg_dl[PW] && v < 0) v = v + 1;
      else if (neg_dl[PW] && v > 0) v = v - 1;
    end
    ok_f = ok_dl[PW] && !((v > avx && v > bvx) || (v < avx && v < bvx));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= ok_f;
      v_o   <= (CoordBits+2)'(v);
    end
  end
endmodule

@@ rtl/core/sbcl_checker.sv @@
// port level checks for the segment box chord length block
module sbcl_checker
  import sbcl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input sbcl_out_t out_data_o
);
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_box |->
      !out_data_o.crosses && out_data_o.chord_length == '0) else $error("bad box");
  a_len_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.crosses |-> out_data_o.chord_length == '0)
    else $error("length without crossing");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("needless stall");
endmodule

bind segment_box_chord_length sbcl_checker u_sbcl_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
